>>> rtl/sat_pkg.sv
package sat_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_INDEX = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic               ins_en;
    logic               del_en;
    logic signed [31:0] key;
  } cell_ctrl_t;

endpackage

>>> rtl/sat_cell.sv
module sat_cell import sat_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CW    = 7,
  parameter int AW    = 7
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [CW-1:0]      count,
  input  logic [AW-1:0]      pos,
  input  logic signed [31:0] prev_val,
  input  logic               prev_gt,
  input  logic signed [31:0] next_val,
  output logic signed [31:0] val,
  output logic               gt,
  output logic               place
);

  localparam logic [CW-1:0] MY_INDEX   = CW'(INDEX);
  localparam logic [CW-1:0] NEXT_INDEX = CW'(INDEX + 1);
  localparam logic [AW-1:0] MY_ADDR    = AW'(INDEX);

  logic occupied;
  logic shift_down;

  assign occupied = MY_INDEX < count;
  assign gt       = occupied && (val > ctrl.key);
  // first cell whose entry is greater than the key, or the first free cell
  assign place    = !prev_gt && (gt || (MY_INDEX == count));
  assign shift_down = (MY_ADDR >= pos) && (NEXT_INDEX < count);

  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (prev_gt) begin
        val <= prev_val;
      end else if (place) begin
        val <= ctrl.key;
      end
    end else if (ctrl.del_en && shift_down) begin
      val <= next_val;
    end
  end

endmodule

>>> rtl/sorted_array_table_unit.sv
// Sorted table of signed 32-bit entries held in a row of cells.
// Insert, delete and get: the request word is registered, executed in the EXEC state and
// moved to the response register in the EMIT state. Search bisects in EXEC, one step per cycle
// through a single read port on the cell row. A new request is taken once the result has
// moved to the response register.
// Synchronous active-high reset empties the table; entry contents are not cleared.
module sorted_array_table_unit import sat_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         operation,
  input  logic signed [31:0] value,
  input  logic [5:0]         position,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic [5:0]         found_index,
  output logic [6:0]         entry_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CW > 7) ? CW : 7;
  localparam int SW = CW + 1;
  localparam int FW = (IW > 6) ? IW : 6;
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  state_t state, state_next;

  op_t                op_q;
  logic signed [31:0] key_q;
  logic [5:0]         pos_q;
  logic [CW-1:0]      count;
  logic signed [SW-1:0] lo, hi;

  status_t            res_status, res_status_next;
  logic signed [31:0] res_data, res_data_next;
  logic [IW-1:0]      res_idx, res_idx_next;
  logic [CW-1:0]      count_next;

  logic req_take, exec_active, emit_load, exec_done, out_free;
  logic ins_go, del_go;

  cell_ctrl_t         ctrl;
  logic signed [31:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_place;

  logic [AW-1:0]      pos_ext, count_ext, rd_addr;
  logic               pos_ok;
  logic [SW:0]        mid_sum;
  logic signed [SW-1:0] mid;
  logic signed [31:0] rd_data;
  logic [IW-1:0]      place_idx;
  logic               range_empty;
  logic [FW-1:0]      idx_wide;
  logic [AW-1:0]      count_wide;

  // ---------------- cell row ----------------
  assign ctrl.ins_en = ins_go;
  assign ctrl.del_en = del_go;
  assign ctrl.key    = key_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sat_cell #(.INDEX(i), .CW(CW), .AW(AW)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count),
      .pos      (pos_ext),
      .prev_val ((i == 0) ? 32'sd0 : cell_val[(i == 0) ? 0 : i - 1]),
      .prev_gt  ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
      .next_val ((i == CAPACITY - 1) ? 32'sd0 : cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .val      (cell_val[i]),
      .gt       (cell_gt[i]),
      .place    (cell_place[i])
    );
  end

  // ---------------- datapath ----------------
  assign pos_ext   = AW'(pos_q);
  assign count_ext = AW'(count);
  assign pos_ok    = pos_ext < count_ext;

  // lo is never negative while lo <= hi, so the sum is non-negative
  assign mid_sum     = {lo[SW-1], lo} + {hi[SW-1], hi};
  assign mid         = signed'(mid_sum[SW:1]);
  assign range_empty = lo > hi;
  assign rd_addr     = (op_q == OP_SEARCH) ? AW'(mid_sum[SW:1]) : pos_ext;

  always_comb begin
    rd_data   = '0;
    place_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (AW'(i) == rd_addr) rd_data = rd_data | cell_val[i];
      if (cell_place[i]) place_idx = place_idx | IW'(i);
    end
  end

  always_comb begin
    res_status_next = STATUS_OK;
    res_data_next   = '0;
    res_idx_next    = '0;
    count_next      = count;
    exec_done       = 1'b1;
    unique case (op_q)
      OP_INSERT: begin
        if (count == FULL_COUNT) begin
          res_status_next = STATUS_FULL;
        end else begin
          res_idx_next = place_idx;
          count_next   = count + CW'(1);
        end
      end
      OP_DELETE: begin
        if (!pos_ok) begin
          res_status_next = STATUS_BAD_INDEX;
        end else begin
          res_data_next = rd_data;
          count_next    = count - CW'(1);
        end
      end
      OP_SEARCH: begin
        if (range_empty) begin
          res_status_next = STATUS_NOT_FOUND;
        end else if (rd_data == key_q) begin
          res_idx_next = IW'(mid_sum[SW:1]);
        end else begin
          exec_done = 1'b0;
        end
      end
      OP_GET: begin
        if (!pos_ok) begin
          res_status_next = STATUS_BAD_INDEX;
        end else begin
          res_data_next = rd_data;
        end
      end
      default: begin
        res_status_next = STATUS_OK;
      end
    endcase
  end

  // ---------------- control ----------------
  assign out_free = !rsp_valid || !rsp_stall;
  assign req_take = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_take) state_next = ST_EXEC;
      ST_EXEC: if (exec_done) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall   = (state != ST_IDLE);
    exec_active = (state == ST_EXEC);
    emit_load   = (state == ST_EMIT) && out_free;
    ins_go      = exec_active && (op_q == OP_INSERT) && (count != FULL_COUNT);
    del_go      = exec_active && (op_q == OP_DELETE) && pos_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_active && exec_done) count <= count_next;
      if (emit_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      op_q  <= op_t'(operation);
      key_q <= value;
      pos_q <= position;
      lo    <= '0;
      hi    <= signed'(SW'(count)) - SW'(1);
    end else if (exec_active && !exec_done) begin
      if (key_q < rd_data) begin
        hi <= mid - SW'(1);
      end else begin
        lo <= mid + SW'(1);
      end
    end
    if (exec_active && exec_done) begin
      res_status <= res_status_next;
      res_data   <= res_data_next;
      res_idx    <= res_idx_next;
    end
  end

  assign idx_wide   = FW'(res_idx);
  assign count_wide = AW'(count);

  always_ff @(posedge clk) begin
    if (emit_load) begin
      status      <= res_status;
      data        <= res_data;
      found_index <= idx_wide[5:0];
      entry_count <= count_wide[6:0];
    end
  end

endmodule

>>> tb/tb_sorted_array_table_unit.sv
`timescale 1ns / 100ps

module tb_sorted_array_table_unit;
  import sat_pkg::*;

  localparam int DEPTH = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PER_PHASE = 150;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] data;
    logic [5:0]         idx;
    logic [6:0]         count;
  } rsp_t;

  typedef struct {
    op_t                op;
    logic signed [31:0] val;
    logic [5:0]         pos;
    bit                 typed;
    rsp_t               want;
  } dir_row_t;

  localparam rsp_t NO_RSP = '{STATUS_OK, 32'sd0, 6'd0, 7'd0};

  logic               clk = 1'b0;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  logic [1:0]         operation;
  logic signed [31:0] value;
  logic [5:0]         position;
  logic               rsp_valid;
  logic               rsp_stall;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [5:0]         found_index;
  logic [6:0]         entry_count;

  // mirror of the table contents
  logic signed [31:0] mirror_entries [DEPTH];
  int                 mirror_count;

  rsp_t     pending_rsp [$];
  dir_row_t dir_rows [$];
  int       errors;
  int       send_idle_pct;
  int       rcv_stall_pct;
  bit       hold_req;
  int       hold_left;

  sorted_array_table_unit #(.CAPACITY(DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .value      (value),
    .position   (position),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .data       (data),
    .found_index(found_index),
    .entry_count(entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic rsp_t table_apply(op_t op, logic signed [31:0] v, logic [5:0] p);
    rsp_t r;
    int   i;
    int   lo;
    int   hi;
    int   mid;
    bit   hit;
    r = NO_RSP;
    case (op)
      OP_INSERT: begin
        if (mirror_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          i = mirror_count;
          // equal entries stay ahead of the new one
          while (i > 0 && mirror_entries[i-1] > v) begin
            mirror_entries[i] = mirror_entries[i-1];
            i--;
          end
          mirror_entries[i] = v;
          mirror_count++;
          r.idx = i[5:0];
        end
      end
      OP_DELETE: begin
        if (p >= mirror_count) begin
          r.status = STATUS_BAD_INDEX;
        end else begin
          r.data = mirror_entries[p];
          for (i = p; i + 1 < mirror_count; i++) mirror_entries[i] = mirror_entries[i+1];
          mirror_count--;
        end
      end
      OP_SEARCH: begin
        lo = 0;
        hi = mirror_count - 1;
        hit = 1'b0;
        while (lo <= hi && !hit) begin
          mid = (lo + hi) / 2;
          if (v == mirror_entries[mid]) begin
            hit = 1'b1;
            r.idx = mid[5:0];
          end else if (v < mirror_entries[mid]) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
        if (!hit) r.status = STATUS_NOT_FOUND;
      end
      default: begin
        if (p >= mirror_count) r.status = STATUS_BAD_INDEX;
        else r.data = mirror_entries[p];
      end
    endcase
    r.count = mirror_count[6:0];
    return r;
  endfunction

  function automatic void add_row(op_t op, logic signed [31:0] v, logic [5:0] p, bit typed,
                                  rsp_t want);
    dir_row_t row;
    row.op = op;
    row.val = v;
    row.pos = p;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  // present one request word, wait until taken, then record what should come back
  task automatic send_word(op_t op, logic signed [31:0] v, logic [5:0] p, bit typed,
                           rsp_t want);
    rsp_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    value     <= v;
    position  <= p;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    got = table_apply(op, v, p);
    pending_rsp.push_back(typed ? want : got);
  endtask

  always @(posedge clk) begin : rcv
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: response word with none expected: status=%0d data=%0d idx=%0d count=%0d",
                 $time, status, data, found_index, entry_count);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (data !== want.data) begin
          $display("%0t: data expected %0d actual %0d", $time, want.data, data);
          errors++;
        end
        if (found_index !== want.idx) begin
          $display("%0t: found_index expected %0d actual %0d", $time, want.idx, found_index);
          errors++;
        end
        if (entry_count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count, entry_count);
          errors++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stim
    int                 ph;
    int                 n;
    int                 r;
    int                 linger;
    bit                 growing;
    op_t                op;
    logic signed [31:0] v;
    logic [5:0]         p;
    int                 send_pct [4];
    int                 stall_pct [4];

    send_pct  = '{0, 45, 0, 13};
    stall_pct = '{0, 0, 45, 13};
    errors = 0;
    hold_req = 1'b0;
    hold_left = 0;
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    mirror_count = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    operation <= OP_INSERT;
    value     <= 32'sd0;
    position  <= 6'd0;
    rsp_stall <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table, extremes, duplicates, bad index, missing key
    add_row(OP_GET,    32'sd0,            6'd0,  1, '{STATUS_BAD_INDEX, 32'sd0, 6'd0, 7'd0});
    add_row(OP_SEARCH, 32'sd0,            6'd0,  1, '{STATUS_NOT_FOUND, 32'sd0, 6'd0, 7'd0});
    add_row(OP_DELETE, 32'sd0,            6'd63, 1, '{STATUS_BAD_INDEX, 32'sd0, 6'd0, 7'd0});
    add_row(OP_INSERT, 32'sh7fffffff,     6'd0,  1, '{STATUS_OK, 32'sd0, 6'd0, 7'd1});
    add_row(OP_INSERT, 32'sh80000000,     6'd0,  1, '{STATUS_OK, 32'sd0, 6'd0, 7'd2});
    add_row(OP_GET,    32'sd0,            6'd0,  1, '{STATUS_OK, 32'sh80000000, 6'd0, 7'd2});
    add_row(OP_GET,    32'sd0,            6'd1,  1, '{STATUS_OK, 32'sh7fffffff, 6'd0, 7'd2});
    add_row(OP_GET,    32'sd0,            6'd2,  1, '{STATUS_BAD_INDEX, 32'sd0, 6'd0, 7'd2});
    add_row(OP_INSERT, 32'sd0,            6'd0,  0, NO_RSP);
    add_row(OP_INSERT, 32'sd0,            6'd0,  0, NO_RSP);
    add_row(OP_INSERT, -32'sd1,           6'd0,  0, NO_RSP);
    add_row(OP_SEARCH, 32'sd0,            6'd0,  0, NO_RSP);
    add_row(OP_SEARCH, 32'sh80000000,     6'd0,  0, NO_RSP);
    add_row(OP_SEARCH, 32'sh7fffffff,     6'd0,  0, NO_RSP);
    add_row(OP_SEARCH, 32'sd5,            6'd0,  1, '{STATUS_NOT_FOUND, 32'sd0, 6'd0, 7'd5});
    add_row(OP_GET,    32'sd0,            6'd63, 1, '{STATUS_BAD_INDEX, 32'sd0, 6'd0, 7'd5});
    add_row(OP_DELETE, 32'sd0,            6'd4,  0, NO_RSP);
    add_row(OP_DELETE, 32'sd0,            6'd0,  0, NO_RSP);
    add_row(OP_GET,    32'sd0,            6'd0,  0, NO_RSP);
    add_row(OP_INSERT, 32'sh55555555,     6'd0,  0, NO_RSP);
    add_row(OP_INSERT, 32'shaaaaaaaa,     6'd0,  0, NO_RSP);
    add_row(OP_SEARCH, -32'sd1,           6'd0,  0, NO_RSP);
    add_row(OP_DELETE, 32'sd0,            6'd3,  0, NO_RSP);

    foreach (dir_rows[k])
      send_word(dir_rows[k].op, dir_rows[k].val, dir_rows[k].pos, dir_rows[k].typed,
                dir_rows[k].want);

    // random traffic: grow to full and linger, shrink to empty and linger, repeat
    growing = 1'b1;
    linger = 0;
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pct[ph];
      rcv_stall_pct = stall_pct[ph];
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 0 && n == 40) hold_req = 1'b1;
        r = $urandom_range(99);
        if (growing)
          op = (r < 60) ? OP_INSERT : (r < 70) ? OP_DELETE : (r < 85) ? OP_SEARCH : OP_GET;
        else
          op = (r < 10) ? OP_INSERT : (r < 60) ? OP_DELETE : (r < 80) ? OP_SEARCH : OP_GET;

        r = $urandom_range(99);
        if (r < 35) begin
          v = $signed($urandom_range(16)) - 8;   // dense keys give duplicates
        end else if (r < 45) begin
          case ($urandom_range(3))
            0: v = 32'sh80000000;
            1: v = 32'sh7fffffff;
            2: v = -32'sd1;
            default: v = 32'sd0;
          endcase
        end else begin
          v = $urandom;
        end
        if (op == OP_SEARCH && mirror_count > 0 && $urandom_range(1))
          v = mirror_entries[$urandom_range(mirror_count - 1)];

        if (mirror_count > 0 && $urandom_range(99) < 80)
          p = $urandom_range(mirror_count - 1);
        else
          p = $urandom_range(63);

        send_word(op, v, p, 0, NO_RSP);

        if (growing && mirror_count == DEPTH) begin
          linger++;
          if (linger > 8) begin
            growing = 1'b0;
            linger = 0;
          end
        end else if (!growing && mirror_count == 0) begin
          linger++;
          if (linger > 4) begin
            growing = 1'b1;
            linger = 0;
          end
        end
      end
    end
    req_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
